// ----- hw/rtl/mtc_pkg.sv -----
// ----------------------------------------------------------------------------
// mtc_pkg: shared types and tables for the markup text cleaner
// Holds sizes, character codes, controller/datapath command and status
// structs, and the named entity table.
// ----------------------------------------------------------------------------
`default_nettype none
package mtc_pkg;

  localparam int LA_BYTES   = 10;
  localparam int NAME_BYTES = 10;
  localparam int LA_W       = $clog2(LA_BYTES + 1);
  localparam int LA_IW      = $clog2(LA_BYTES);
  localparam int NAME_W     = $clog2(NAME_BYTES + 2);
  localparam int NAME_IW    = $clog2(NAME_BYTES);
  localparam int CODE_W     = 24;
  localparam int N_ENT      = 17;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_OTHER   = 2'd1;
  localparam logic [1:0] KIND_NEWLINE = 2'd2;

  localparam logic [1:0] GAP_SPACE    = 2'b01;
  localparam logic [1:0] GAP_NEWLINE  = 2'b10;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SL   = 8'h2F;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_TAB  = 8'h09;

  typedef struct packed {
    logic absorb_in;
    logic absorb_rep;
    logic dec_ok;
    logic dec_fail;
    logic copy_step;
    logic put_step;
    logic end_step;
  } cmd_t;

  typedef struct packed {
    logic put_busy;
    logic out_free;
    logic fire;
    logic code_ok;
    logic rem_nz;
    logic rep_avail;
    logic copy_busy;
    logic last;
  } sts_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  // Names are left-justified in 48 bits.
  function automatic logic [47:0] ent_name(input logic [4:0] e);
    logic [47:0] w;
    case (e)
      5'd0:  w = {"amp", 24'h0};
      5'd1:  w = {"lt", 32'h0};
      5'd2:  w = {"gt", 32'h0};
      5'd3:  w = {"quot", 16'h0};
      5'd4:  w = {"apos", 16'h0};
      5'd5:  w = {"nbsp", 16'h0};
      5'd6:  w = {"ldquo", 8'h0};
      5'd7:  w = {"rdquo", 8'h0};
      5'd8:  w = {"lsquo", 8'h0};
      5'd9:  w = {"rsquo", 8'h0};
      5'd10: w = {"ndash", 8'h0};
      5'd11: w = {"mdash", 8'h0};
      5'd12: w = "hellip";
      5'd13: w = {"euro", 16'h0};
      5'd14: w = {"copy", 16'h0};
      5'd15: w = {"reg", 24'h0};
      5'd16: w = {"trade", 8'h0};
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] ent_len(input logic [4:0] e);
    logic [3:0] n;
    case (e)
      5'd1, 5'd2: n = 4'd2;
      5'd0, 5'd15: n = 4'd3;
      5'd3, 5'd4, 5'd5, 5'd13, 5'd14: n = 4'd4;
      5'd12: n = 4'd6;
      5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd16: n = 4'd5;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [15:0] ent_code(input logic [4:0] e);
    logic [15:0] v;
    case (e)
      5'd0:  v = 16'd38;
      5'd1:  v = 16'd60;
      5'd2:  v = 16'd62;
      5'd3:  v = 16'd34;
      5'd4:  v = 16'd39;
      5'd5:  v = 16'd32;
      5'd6:  v = 16'd8220;
      5'd7:  v = 16'd8221;
      5'd8:  v = 16'd8216;
      5'd9:  v = 16'd8217;
      5'd10: v = 16'd8211;
      5'd11: v = 16'd8212;
      5'd12: v = 16'd8230;
      5'd13: v = 16'd8364;
      5'd14: v = 16'd169;
      5'd15: v = 16'd174;
      5'd16: v = 16'd8482;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] ent_chr(input logic [4:0] e, input logic [LA_W-1:0] k);
    logic [47:0] w;
    logic [7:0]  c;
    w = ent_name(e);
    case (k)
      LA_W'(0): c = w[47:40];
      LA_W'(1): c = w[39:32];
      LA_W'(2): c = w[31:24];
      LA_W'(3): c = w[23:16];
      LA_W'(4): c = w[15:8];
      LA_W'(5): c = w[7:0];
      default:  c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mtc_ctrl.sv -----
// ----------------------------------------------------------------------------
// mtc_ctrl: sequencing controller
// Takes a byte, then steps the entity check, replay, copy and output drain
// until the byte's work is done, and sends the end marker after the last byte.
// ----------------------------------------------------------------------------
`default_nettype none
module mtc_ctrl
  import mtc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] S_IN   = 2'd0;
  localparam logic [1:0] S_CHK  = 2'd1;
  localparam logic [1:0] S_COPY = 2'd2;
  localparam logic [1:0] S_END  = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IN);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IN: begin
        if (in_valid) begin
          cmd.absorb_in = 1'b1;
          state_nxt     = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.put_busy) begin
          cmd.put_step = 1'b1;
        end else if (sts.fire) begin
          if (sts.code_ok) begin
            cmd.dec_ok = 1'b1;
          end else begin
            cmd.dec_fail = 1'b1;
            if (sts.rem_nz) state_nxt = S_COPY;
          end
        end else if (sts.rep_avail) begin
          cmd.absorb_rep = 1'b1;
        end else if (sts.last) begin
          state_nxt = S_END;
        end else begin
          state_nxt = S_IN;
        end
      end
      S_COPY: begin
        if (sts.copy_busy) cmd.copy_step = 1'b1;
        else state_nxt = S_CHK;
      end
      S_END: begin
        cmd.end_step = 1'b1;
        if (sts.out_free) state_nxt = S_IN;
      end
      default: state_nxt = S_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IN;
    else state_r <= state_nxt;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mtc_dp.sv -----
// ----------------------------------------------------------------------------
// mtc_dp: cleaner datapath
// Stream state, lookahead buffer with running entity decode, put queue with
// whitespace gap drain, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module mtc_dp
  import mtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_end_marker
);

  logic              in_markup_r, in_markup_nxt;
  logic              closing_r, closing_nxt;
  logic              nf_r, nf_nxt;
  logic [7:0]        name_r [NAME_BYTES];
  logic [7:0]        name_nxt [NAME_BYTES];
  logic [NAME_W-1:0] nlen_r, nlen_nxt;
  logic              lws_r, lws_nxt;
  logic [1:0]        nlc_r, nlc_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [1:0]        gap_r, gap_nxt;
  logic [7:0]        buf_r [LA_BYTES];
  logic [7:0]        buf_nxt [LA_BYTES];
  logic [LA_W-1:0]   cnt_r, cnt_nxt;
  logic [LA_W-1:0]   ri_r, ri_nxt;
  logic [LA_W-1:0]   rend_r, rend_nxt;
  logic              last_r, last_nxt;
  logic              hash_r, hash_nxt;
  logic              isx_r, isx_nxt;
  logic              semi_r, semi_nxt;
  logic [CODE_W-1:0] dec_r, dec_nxt;
  logic [CODE_W-1:0] hex_r, hex_nxt;
  logic [N_ENT-1:0]  alive_r, alive_nxt;
  logic [LA_W-1:0]   cp_dst_r, cp_dst_nxt;
  logic [LA_W-1:0]   cp_left_r, cp_left_nxt;
  logic [7:0]        pq_r [4];
  logic [7:0]        pq_nxt [4];
  logic [2:0]        pq_n_r, pq_n_nxt;
  logic [2:0]        pq_i_r, pq_i_nxt;
  logic              pq_ent_r, pq_ent_nxt;
  logic [7:0]        marker_r;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_bv_r, out_bv_nxt;
  logic              out_end_r, out_end_nxt;

  logic [7:0]        x_abs, x_p, rd_byte, l0, l1;
  logic              plain_en, out_free, emit;
  logic [15:0]       named;
  logic [CODE_W-1:0] code_w;
  logic [7:0]        u8 [4];
  logic [2:0]        u8_n;
  logic [LA_W-1:0]   k_pos, rem;
  logic [3:0]        hv;
  logic [NAME_W-1:0] tlen;
  logic              t_match, t_head, t_empty, t_back;
  logic [7:0]        low [NAME_BYTES];
  logic [79:0]       low_w;

  assign rd_byte  = buf_r[ri_r[LA_IW-1:0]];
  assign out_free = !out_valid_r || !out_stall;

  // Decoded code point from the running accumulators.
  always_comb begin
    named = '0;
    for (int e = 0; e < N_ENT; e++) begin
      if (alive_r[e]) named = named | ent_code(5'(e));
    end
    if (!semi_r) code_w = '0;
    else if (hash_r) code_w = isx_r ? hex_r : dec_r;
    else code_w = CODE_W'(named);
  end

  // UTF-8 encoding.
  always_comb begin
    u8[0] = code_w[7:0];
    u8[1] = 8'h00;
    u8[2] = 8'h00;
    u8[3] = 8'h00;
    u8_n  = 3'd1;
    if (code_w > CODE_W'(24'h7FF) && code_w > CODE_W'(24'hFFFF)) begin
      u8[0] = 8'hF0 | {5'd0, code_w[20:18]};
      u8[1] = 8'h80 | {2'd0, code_w[17:12]};
      u8[2] = 8'h80 | {2'd0, code_w[11:6]};
      u8[3] = 8'h80 | {2'd0, code_w[5:0]};
      u8_n  = 3'd4;
    end else if (code_w > CODE_W'(24'h7FF)) begin
      u8[0] = 8'hE0 | {4'd0, code_w[15:12]};
      u8[1] = 8'h80 | {2'd0, code_w[11:6]};
      u8[2] = 8'h80 | {2'd0, code_w[5:0]};
      u8_n  = 3'd3;
    end else if (code_w > CODE_W'(24'h7F)) begin
      u8[0] = 8'hC0 | {3'd0, code_w[10:6]};
      u8[1] = 8'h80 | {2'd0, code_w[5:0]};
      u8_n  = 3'd2;
    end
  end

  // Block tag match on the lowercased name.
  always_comb begin
    for (int i = 0; i < NAME_BYTES; i++) low[i] = to_lower(name_r[i]);
    low_w = {low[0], low[1], low[2], low[3], low[4], low[5], low[6], low[7], low[8], low[9]};
    l0    = low[0];
    l1    = low[1];
    tlen  = (nlen_r > NAME_W'(NAME_BYTES)) ? '0 : nlen_r;
    t_head  = (tlen == NAME_W'(2)) && l0 == "h" && l1 >= "1" && l1 <= "6";
    t_match = t_head
           || (tlen == NAME_W'(1) && l0 == "p")
           || (tlen == NAME_W'(3) && {l0, l1, low[2]} == "div")
           || (tlen == NAME_W'(2) && ({l0, l1} == "li" || {l0, l1} == "tr"
                                      || {l0, l1} == "br"))
           || (tlen == NAME_W'(10) && low_w == "blockquote");
    t_empty = (gap_r == 2'b00) && (kind_r == KIND_NONE);
    t_back  = (gap_r != 2'b00) ? gap_r[1] : (kind_r == KIND_NEWLINE);
  end

  assign k_pos = cnt_r - LA_W'(1);
  assign rem   = rend_r - ri_r;

  always_comb begin
    in_markup_nxt = in_markup_r;
    closing_nxt   = closing_r;
    nf_nxt        = nf_r;
    name_nxt      = name_r;
    nlen_nxt      = nlen_r;
    lws_nxt       = lws_r;
    nlc_nxt       = nlc_r;
    kind_nxt      = kind_r;
    gap_nxt       = gap_r;
    buf_nxt       = buf_r;
    cnt_nxt       = cnt_r;
    ri_nxt        = ri_r;
    rend_nxt      = rend_r;
    last_nxt      = last_r;
    hash_nxt      = hash_r;
    isx_nxt       = isx_r;
    semi_nxt      = semi_r;
    dec_nxt       = dec_r;
    hex_nxt       = hex_r;
    alive_nxt     = alive_r;
    cp_dst_nxt    = cp_dst_r;
    cp_left_nxt   = cp_left_r;
    pq_nxt        = pq_r;
    pq_n_nxt      = pq_n_r;
    pq_i_nxt      = pq_i_r;
    pq_ent_nxt    = pq_ent_r;
    emit          = 1'b0;
    out_byte_nxt  = out_byte_r;
    out_bv_nxt    = out_bv_r;
    out_end_nxt   = out_end_r;
    plain_en      = 1'b0;
    x_abs         = cmd.absorb_in ? in_text_byte : rd_byte;
    x_p           = x_abs;
    hv            = '0;

    if (cmd.absorb_in) begin
      last_nxt = in_end_of_text;
      ri_nxt   = '0;
      rend_nxt = '0;
    end
    if (cmd.absorb_rep) ri_nxt = ri_r + LA_W'(1);

    // Absorb: extend a held entity, start one, or process as plain text.
    if (cmd.absorb_in || cmd.absorb_rep) begin
      if (cnt_r != '0) begin
        if (cnt_r < LA_W'(LA_BYTES)) begin
          buf_nxt[cnt_r[LA_IW-1:0]] = x_abs;
          cnt_nxt  = cnt_r + LA_W'(1);
          semi_nxt = (x_abs == CH_SEMI);
          if (cnt_r == LA_W'(1)) hash_nxt = (x_abs == CH_HASH);
          if (cnt_r == LA_W'(2)) isx_nxt = (x_abs == "x") || (x_abs == "X");
          if (cnt_r >= LA_W'(2) && is_digit(x_abs))
            dec_nxt = {dec_r[CODE_W-4:0], 3'b000} + {dec_r[CODE_W-2:0], 1'b0}
                    + CODE_W'(x_abs - 8'h30);
          if (is_digit(x_abs)) hv = 4'(x_abs - 8'h30);
          else if (x_abs >= "a" && x_abs <= "f") hv = 4'(x_abs - 8'h57);
          else hv = 4'(x_abs - 8'h37);
          if (cnt_r >= LA_W'(3) && (is_digit(x_abs) || (x_abs >= "a" && x_abs <= "f")
                                    || (x_abs >= "A" && x_abs <= "F")))
            hex_nxt = {hex_r[CODE_W-5:0], hv};
          for (int e = 0; e < N_ENT; e++) begin
            if (k_pos < LA_W'(ent_len(5'(e))))
              alive_nxt[e] = alive_r[e] && (x_abs == ent_chr(5'(e), k_pos));
            else if (k_pos == LA_W'(ent_len(5'(e))))
              alive_nxt[e] = alive_r[e] && (x_abs == CH_SEMI);
            else
              alive_nxt[e] = 1'b0;
          end
        end
      end else if (x_abs == CH_AMP) begin
        buf_nxt[0] = x_abs;
        cnt_nxt    = LA_W'(1);
        hash_nxt   = 1'b0;
        isx_nxt    = 1'b0;
        semi_nxt   = 1'b0;
        dec_nxt    = '0;
        hex_nxt    = '0;
        alive_nxt  = '1;
      end else begin
        plain_en = 1'b1;
      end
    end

    // Failed entity: the ampersand goes out as text, held bytes replay.
    if (cmd.dec_fail) begin
      cnt_nxt     = '0;
      plain_en    = 1'b1;
      x_p         = CH_AMP;
      cp_dst_nxt  = cnt_r;
      cp_left_nxt = rem;
      rend_nxt    = cnt_r + rem;
      if (rem == '0) ri_nxt = LA_W'(1);
    end

    if (cmd.dec_ok) begin
      cnt_nxt = '0;
      if (code_w == CODE_W'(32)) begin
        if (!lws_r) begin
          gap_nxt = GAP_SPACE;
          lws_nxt = 1'b1;
        end
      end else begin
        pq_nxt     = u8;
        pq_n_nxt   = u8_n;
        pq_i_nxt   = '0;
        pq_ent_nxt = 1'b1;
        lws_nxt    = 1'b0;
      end
    end

    // Move the unread tail behind the failed entity's bytes.
    if (cmd.copy_step && cp_left_r != '0) begin
      buf_nxt[cp_dst_r[LA_IW-1:0]] = rd_byte;
      cp_dst_nxt  = cp_dst_r + LA_W'(1);
      cp_left_nxt = cp_left_r - LA_W'(1);
      ri_nxt      = (cp_left_r == LA_W'(1)) ? LA_W'(1) : ri_r + LA_W'(1);
    end

    if (plain_en) begin
      if (x_p == CH_LT) begin
        in_markup_nxt = 1'b1;
        closing_nxt   = 1'b0;
        nf_nxt        = 1'b0;
        nlen_nxt      = '0;
      end else if (x_p == CH_GT) begin
        in_markup_nxt = 1'b0;
        nlen_nxt      = '0;
        nf_nxt        = 1'b0;
        closing_nxt   = 1'b0;
        if (t_match) begin
          if (!t_empty && !t_back) begin
            gap_nxt = gap_r | GAP_NEWLINE;
            lws_nxt = 1'b1;
          end
          if (t_head && !closing_r) begin
            pq_nxt[0]  = marker_r;
            pq_n_nxt   = 3'd1;
            pq_i_nxt   = '0;
            pq_ent_nxt = 1'b0;
          end
        end
      end else if (in_markup_r) begin
        if (nlen_r == '0) begin
          if (x_p == CH_SL) begin
            closing_nxt = 1'b1;
          end else if (is_alpha(x_p)) begin
            name_nxt[0] = x_p;
            nlen_nxt    = NAME_W'(1);
          end
        end else if (!nf_r) begin
          if (is_alpha(x_p) || is_digit(x_p)) begin
            if (nlen_r < NAME_W'(NAME_BYTES)) begin
              name_nxt[nlen_r[NAME_IW-1:0]] = x_p;
              nlen_nxt = nlen_r + NAME_W'(1);
            end else begin
              nlen_nxt = NAME_W'(NAME_BYTES + 1);
              nf_nxt   = 1'b1;
            end
          end else begin
            nf_nxt = 1'b1;
          end
        end
      end else if (x_p == CH_NL || x_p == CH_CR || x_p == CH_TAB || x_p == CH_SP) begin
        if (x_p == CH_NL && nlc_r < 2'd2) nlc_nxt = nlc_r + 2'd1;
        if (!lws_r) begin
          gap_nxt = GAP_SPACE;
          lws_nxt = 1'b1;
        end
      end else begin
        if (nlc_r >= 2'd2 && gap_r == GAP_SPACE) gap_nxt = GAP_NEWLINE;
        nlc_nxt    = '0;
        lws_nxt    = 1'b0;
        pq_nxt[0]  = x_p;
        pq_n_nxt   = 3'd1;
        pq_i_nxt   = '0;
        pq_ent_nxt = 1'b0;
      end
    end

    // Drain: held whitespace first, then the queued bytes.
    if (cmd.put_step && out_free) begin
      emit        = 1'b1;
      out_bv_nxt  = 1'b1;
      out_end_nxt = 1'b0;
      if (gap_r[0]) begin
        out_byte_nxt = CH_SP;
        gap_nxt      = gap_r & ~GAP_SPACE;
      end else if (gap_r[1]) begin
        out_byte_nxt = CH_NL;
        gap_nxt      = gap_r & ~GAP_NEWLINE;
      end else begin
        out_byte_nxt = pq_r[pq_i_r[1:0]];
        pq_i_nxt     = pq_i_r + 3'd1;
        kind_nxt     = (pq_ent_r && pq_r[pq_i_r[1:0]] == CH_NL) ? KIND_NEWLINE : KIND_OTHER;
      end
    end

    if (cmd.end_step && out_free) begin
      emit          = 1'b1;
      out_byte_nxt  = 8'h00;
      out_bv_nxt    = 1'b0;
      out_end_nxt   = 1'b1;
      in_markup_nxt = 1'b0;
      closing_nxt   = 1'b0;
      nf_nxt        = 1'b0;
      nlen_nxt      = '0;
      lws_nxt       = 1'b1;
      nlc_nxt       = '0;
      kind_nxt      = KIND_NONE;
      gap_nxt       = '0;
      cnt_nxt       = '0;
      ri_nxt        = '0;
      rend_nxt      = '0;
      last_nxt      = 1'b0;
    end

    out_valid_nxt = (out_valid_r && out_stall) ? 1'b1 : emit;
  end

  always_comb begin
    sts.put_busy  = (pq_i_r != pq_n_r);
    sts.out_free  = out_free;
    sts.fire      = (cnt_r != '0) && (semi_r || cnt_r >= LA_W'(LA_BYTES)
                                      || (last_r && ri_r >= rend_r));
    sts.code_ok   = (code_w != '0);
    sts.rem_nz    = (rem != '0);
    sts.rep_avail = (ri_r < rend_r);
    sts.copy_busy = (cp_left_r != '0);
    sts.last      = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_markup_r <= 1'b0;
      closing_r   <= 1'b0;
      nf_r        <= 1'b0;
      nlen_r      <= '0;
      lws_r       <= 1'b1;
      nlc_r       <= '0;
      kind_r      <= KIND_NONE;
      gap_r       <= '0;
      cnt_r       <= '0;
      ri_r        <= '0;
      rend_r      <= '0;
      last_r      <= 1'b0;
      cp_left_r   <= '0;
      pq_n_r      <= '0;
      pq_i_r      <= '0;
      out_valid_r <= 1'b0;
      marker_r    <= 8'd1;
    end else begin
      in_markup_r <= in_markup_nxt;
      closing_r   <= closing_nxt;
      nf_r        <= nf_nxt;
      nlen_r      <= nlen_nxt;
      lws_r       <= lws_nxt;
      nlc_r       <= nlc_nxt;
      kind_r      <= kind_nxt;
      gap_r       <= gap_nxt;
      cnt_r       <= cnt_nxt;
      ri_r        <= ri_nxt;
      rend_r      <= rend_nxt;
      last_r      <= last_nxt;
      cp_left_r   <= cp_left_nxt;
      pq_n_r      <= pq_n_nxt;
      pq_i_r      <= pq_i_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) marker_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    name_r     <= name_nxt;
    buf_r      <= buf_nxt;
    hash_r     <= hash_nxt;
    isx_r      <= isx_nxt;
    semi_r     <= semi_nxt;
    dec_r      <= dec_nxt;
    hex_r      <= hex_nxt;
    alive_r    <= alive_nxt;
    cp_dst_r   <= cp_dst_nxt;
    pq_r       <= pq_nxt;
    pq_ent_r   <= pq_ent_nxt;
    out_byte_r <= out_byte_nxt;
    out_bv_r   <= out_bv_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_bv_r;
  assign out_end_marker = out_end_r;

endmodule
`default_nettype wire

// ----- hw/rtl/markup_text_cleaner.sv -----
// ----------------------------------------------------------------------------
// markup_text_cleaner: tag stripper and entity decoder for a text byte stream
// Strips tags, decodes entities to UTF-8, collapses whitespace, turns block
// tags into newlines and closes each text with an end marker beat.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid / in_stall | in_text_byte[7:0], in_end_of_text
//  out     | out_valid/out_stall | out_byte[7:0], out_byte_valid, out_end_marker
//  cfg     | cfg_we              | cfg_data[7:0] (heading marker, reset 1)
//
//  A beat is absorbed, then the sequencer steps through each output beat, each
//  entity decision and a closing step before it takes the next beat. A failed
//  entity replays each held byte, and moves the unread bytes behind them when
//  any remain; the end of a text adds the end marker beat.
//  Reset is synchronous, active low; it needs no clearing pass.
//  An output stall holds the sequencer; the output register holds its beat.
// ----------------------------------------------------------------------------
`default_nettype none
module markup_text_cleaner
  import mtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_end_marker,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  // Controller issues one command per cycle; datapath reports back status.
  cmd_t cmd;
  sts_t sts;

  mtc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath holds all stream state, the lookahead buffer and output beat.
  mtc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_end_marker (out_end_marker)
  );

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: markup text cleaner regression
// Drives text beats into the cleaner and predicts every cleaned beat with a
// cycle-free model of tag stripping, entity decoding and whitespace folding.
// Runs directed texts, then random texts under several idle/stall mixes and
// heading marker values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import mtc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       is_data;
    logic       is_end;
  } clean_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_text_byte = 8'h00;
  logic       in_end_of_text = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_end_marker;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_data = 8'h00;

  markup_text_cleaner dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_text_byte(in_text_byte), .in_end_of_text(in_end_of_text),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .out_byte_valid(out_byte_valid),
    .out_end_marker(out_end_marker),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Percent chance per cycle that the sender idles / the receiver stalls.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          error_count = 0;
  int          beats_sent = 0;

  clean_beat_t cleaned_q[$];

  // --------------------------------------------------------------------------
  // Cleaner state as the predictor sees it
  // --------------------------------------------------------------------------
  logic [7:0] marker_byte = 8'd1;
  logic       in_tag, tag_closing, tag_name_done, prev_space;
  logic [7:0] tag_name [NAME_BYTES];
  int         tag_len;
  int         newline_run;
  logic [1:0] prev_kind, held_gap;
  logic [7:0] ent_buf [LA_BYTES];
  int         ent_cnt, replay_pos;
  int         beats_this_step;

  function void clear_stream();
    in_tag = 0; tag_closing = 0; tag_name_done = 0; prev_space = 1;
    for (int i = 0; i < NAME_BYTES; i++) tag_name[i] = 8'h00;
    for (int i = 0; i < LA_BYTES; i++) ent_buf[i] = 8'h00;
    tag_len = 0; newline_run = 0; prev_kind = KIND_NONE; held_gap = 2'b00;
    ent_cnt = 0; replay_pos = 0;
  endfunction

  // Queue one expected beat; beats past twenty in one step are not queued.
  function void expect_beat(logic [7:0] b, logic v, logic e);
    clean_beat_t nb;
    if (beats_this_step < 20) begin
      nb.data = b; nb.is_data = v; nb.is_end = e;
      cleaned_q.insert(cleaned_q.size(), nb);
      beats_this_step++;
    end
  endfunction

  // Emit a content byte, flushing any held whitespace first.
  function void put_content(logic [7:0] b, logic [1:0] k);
    if (held_gap & GAP_SPACE) expect_beat(CH_SP, 1'b1, 1'b0);
    if (held_gap & GAP_NEWLINE) expect_beat(CH_NL, 1'b1, 1'b0);
    held_gap = 2'b00;
    expect_beat(b, 1'b1, 1'b0);
    prev_kind = k;
  endfunction

  function logic alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function logic digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Close a tag: block tags request a newline, opening headings add the marker.
  function void close_tag();
    logic [79:0] nm;
    logic [7:0]  c;
    int          n;
    int          cls;
    logic        empty, back_nl;
    n = tag_len;
    nm = '0;
    if (n > NAME_BYTES) n = 0;
    for (int i = 0; i < n; i++) begin
      c = tag_name[i];
      nm[79-8*i -: 8] = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    end
    cls = 0;
    if (n > 0) begin
      case (nm)
        {"p", 72'h0}, {"div", 56'h0}, {"li", 64'h0}, {"tr", 64'h0},
        {"br", 64'h0}, "blockquote": cls = 1;
        {"h1", 64'h0}, {"h2", 64'h0}, {"h3", 64'h0}, {"h4", 64'h0},
        {"h5", 64'h0}, {"h6", 64'h0}: cls = 2;
        default: cls = 0;
      endcase
    end
    if (cls != 0) begin
      empty = held_gap == 2'b00 && prev_kind == KIND_NONE;
      back_nl = (held_gap != 2'b00) ? ((held_gap & GAP_NEWLINE) != 0)
                                    : (prev_kind == KIND_NEWLINE);
      if (!empty && !back_nl) begin
        held_gap |= GAP_NEWLINE;
        prev_space = 1;
      end
      if (cls == 2 && !tag_closing) put_content(marker_byte, KIND_OTHER);
    end
  endfunction

  function void plain_byte(logic [7:0] x);
    if (x == CH_LT) begin
      in_tag = 1; tag_closing = 0; tag_name_done = 0; tag_len = 0;
      return;
    end
    if (x == CH_GT) begin
      in_tag = 0;
      close_tag();
      tag_len = 0; tag_name_done = 0; tag_closing = 0;
      return;
    end
    if (in_tag) begin
      if (tag_len == 0) begin
        if (x == CH_SL) tag_closing = 1;
        else if (alpha(x)) tag_name[tag_len++] = x;
      end else if (!tag_name_done) begin
        if (alpha(x) || digit(x)) begin
          if (tag_len < NAME_BYTES) tag_name[tag_len++] = x;
          else begin
            tag_len = NAME_BYTES + 1;
            tag_name_done = 1;
          end
        end else begin
          tag_name_done = 1;
        end
      end
      return;
    end
    if (x == CH_NL || x == CH_CR || x == CH_TAB || x == CH_SP) begin
      if (x == CH_NL && newline_run < 2) newline_run++;
      if (!prev_space) begin
        held_gap = GAP_SPACE;
        prev_space = 1;
      end
    end else begin
      if (newline_run >= 2 && held_gap == GAP_SPACE) held_gap = GAP_NEWLINE;
      newline_run = 0;
      put_content(x, KIND_OTHER);
      prev_space = 0;
    end
  endfunction

  // Value of the held entity, zero when it is not a valid one.
  function longint unsigned entity_value();
    longint unsigned v;
    logic [47:0]     w;
    logic [7:0]      c;
    int              n, want;
    longint unsigned named;
    v = 0;
    if (ent_cnt < 3 || ent_cnt > LA_BYTES || ent_buf[ent_cnt-1] != CH_SEMI) return 0;
    n = ent_cnt - 2;
    if (ent_buf[1] == CH_HASH) begin
      if (n > 2 && (ent_buf[2] == "x" || ent_buf[2] == "X")) begin
        for (int k = 2; k < n; k++) begin
          c = ent_buf[k+1];
          if (digit(c)) v = v * 16 + (c - "0");
          else if (c >= "a" && c <= "f") v = v * 16 + (c - "a" + 10);
          else if (c >= "A" && c <= "F") v = v * 16 + (c - "A" + 10);
        end
      end else begin
        for (int k = 1; k < n; k++)
          if (digit(ent_buf[k+1])) v = v * 10 + (ent_buf[k+1] - "0");
      end
      return v;
    end
    if (n > 6) return 0;
    w = '0;
    for (int k = 0; k < n; k++) w[47-8*k -: 8] = ent_buf[k+1];
    want = 0; named = 0;
    case (w)
      {"amp", 24'h0}:   begin want = 3; named = 38; end
      {"lt", 32'h0}:    begin want = 2; named = 60; end
      {"gt", 32'h0}:    begin want = 2; named = 62; end
      {"quot", 16'h0}:  begin want = 4; named = 34; end
      {"apos", 16'h0}:  begin want = 4; named = 39; end
      {"nbsp", 16'h0}:  begin want = 4; named = 32; end
      {"ldquo", 8'h0}:  begin want = 5; named = 8220; end
      {"rdquo", 8'h0}:  begin want = 5; named = 8221; end
      {"lsquo", 8'h0}:  begin want = 5; named = 8216; end
      {"rsquo", 8'h0}:  begin want = 5; named = 8217; end
      {"ndash", 8'h0}:  begin want = 5; named = 8211; end
      {"mdash", 8'h0}:  begin want = 5; named = 8212; end
      "hellip":         begin want = 6; named = 8230; end
      {"euro", 16'h0}:  begin want = 4; named = 8364; end
      {"copy", 16'h0}:  begin want = 4; named = 169; end
      {"reg", 24'h0}:   begin want = 3; named = 174; end
      {"trade", 8'h0}:  begin want = 5; named = 8482; end
      default:          want = 0;
    endcase
    return (want == n) ? named : 0;
  endfunction

  // UTF-8 encode a decoded code point; a decoded space folds like a raw one.
  function void emit_code(longint unsigned v);
    logic [7:0] u [4];
    int         n;
    if (v == 32) begin
      if (!prev_space) begin
        held_gap = GAP_SPACE;
        prev_space = 1;
      end
      return;
    end
    if (v <= 'h7F) begin
      u[0] = v[7:0]; n = 1;
    end else if (v <= 'h7FF) begin
      u[0] = 8'hC0 | v[10:6]; u[1] = 8'h80 | v[5:0]; n = 2;
    end else if (v <= 'hFFFF) begin
      u[0] = 8'hE0 | v[15:12]; u[1] = 8'h80 | v[11:6]; u[2] = 8'h80 | v[5:0]; n = 3;
    end else begin
      u[0] = 8'hF0 | v[20:18]; u[1] = 8'h80 | v[17:12];
      u[2] = 8'h80 | v[11:6];  u[3] = 8'h80 | v[5:0]; n = 4;
    end
    for (int i = 0; i < n; i++) put_content(u[i], (u[i] == CH_NL) ? KIND_NEWLINE : KIND_OTHER);
    prev_space = 0;
  endfunction

  function void take_byte(logic [7:0] x);
    if (ent_cnt > 0) begin
      if (ent_cnt < LA_BYTES) ent_buf[ent_cnt++] = x;
    end else if (x == CH_AMP) begin
      ent_buf[0] = x;
      ent_cnt = 1;
    end else begin
      plain_byte(x);
    end
  endfunction

  // Predict every beat caused by one accepted text beat.
  function void predict_clean(logic [7:0] x, logic last);
    int              c, rend, rem;
    longint unsigned v;
    logic [7:0]      held [LA_BYTES];
    beats_this_step = 0;
    replay_pos = 0;
    rend = 0;
    take_byte(x);
    forever begin
      c = ent_cnt;
      if (c > 0 && (ent_buf[c-1] == CH_SEMI || c >= LA_BYTES ||
                    (last && replay_pos >= rend))) begin
        v = entity_value();
        if (v != 0) begin
          ent_cnt = 0;
          emit_code(v);
        end else begin
          // Failed entity: send '&' as text, replay what was held after it.
          rem = rend - replay_pos;
          ent_cnt = 0;
          plain_byte(CH_AMP);
          for (int k = 0; k < rem; k++)
            if (replay_pos + k < LA_BYTES) held[k] = ent_buf[replay_pos + k];
          for (int k = 0; k < rem; k++)
            if (c + k < LA_BYTES && replay_pos + k < LA_BYTES) ent_buf[c + k] = held[k];
          rend = c + rem;
          replay_pos = 1;
        end
        continue;
      end
      if (replay_pos < rend && replay_pos < LA_BYTES) begin
        take_byte(ent_buf[replay_pos++]);
        continue;
      end
      break;
    end
    replay_pos = 0;
    if (last) begin
      held_gap = 2'b00;
      expect_beat(8'h00, 1'b0, 1'b1);
      clear_stream();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result side: stall at random, compare each taken beat with the oldest one
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  always @(posedge clk) begin
    clean_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (cleaned_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %h/%b/%b",
                                  out_byte, out_byte_valid, out_end_marker));
      end else begin
        want = cleaned_q.pop_front();
        if (out_byte !== want.data)
          report_mismatch($sformatf("out_byte %h, want %h", out_byte, want.data));
        if (out_byte_valid !== want.is_data)
          report_mismatch($sformatf("out_byte_valid %b, want %b", out_byte_valid, want.is_data));
        if (out_end_marker !== want.is_end)
          report_mismatch($sformatf("out_end_marker %b, want %b", out_end_marker, want.is_end));
      end
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Send one text beat; valid stays high into the next beat unless we idle.
  task automatic send_beat(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= b;
    in_end_of_text <= last;
    do @(posedge clk); while (in_stall);
    predict_clean(b, last);
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], i == s.len() - 1);
  endtask

  // Hold until every expected beat is out, then let the sequencer settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (cleaned_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_marker(input logic [7:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    marker_byte = v;
  endtask

  // Random text built mostly from well-formed pieces, with some raw noise.
  function automatic string random_text();
    string s, tags [20], ents [24];
    int    pieces;
    tags = '{"p", "div", "li", "tr", "br", "blockquote", "h1", "h2", "h3", "h4",
             "h5", "h6", "H3", "DiV", "BlockQuote", "span", "b", "h7",
             "averylongtagname", "p2"};
    ents = '{"&amp;", "&lt;", "&gt;", "&quot;", "&apos;", "&nbsp;", "&ldquo;",
             "&rdquo;", "&lsquo;", "&rsquo;", "&ndash;", "&mdash;", "&hellip;",
             "&euro;", "&copy;", "&reg;", "&trade;", "&#10;", "&#32;", "&#0;",
             "&bogus;", "& ", "&amp", "&#xZ4g1;"};
    s = "";
    pieces = $urandom_range(1, 5);
    repeat (pieces) begin
      case ($urandom_range(0, 9))
        0, 1: repeat ($urandom_range(1, 5)) s = {s, string'(8'($urandom_range("a", "z")))};
        2: repeat ($urandom_range(1, 4)) begin
             case ($urandom_range(0, 3))
               0: s = {s, " "};
               1: s = {s, "\n"};
               2: s = {s, "\t"};
               default: s = {s, "\r"};
             endcase
           end
        3, 4: s = {s, "<", ($urandom_range(0, 2) == 0) ? "/" : "",
                   tags[$urandom_range(0, 19)],
                   ($urandom_range(0, 3) == 0) ? " id=&lt;x" : "", ">"};
        5, 6: s = {s, ents[$urandom_range(0, 23)]};
        7: s = {s, ($urandom_range(0, 1) != 0) ?
                   $sformatf("&#%0d;", $urandom_range(1, 1200000)) :
                   $sformatf("&#x%0h;", $urandom_range(1, 'h1FFFFF))};
        default: repeat ($urandom_range(1, 3)) begin
          logic [7:0] r;
          r = 8'($urandom_range(1, 255));
          s = {s, string'(r)};
        end
      endcase
    end
    return s;
  endfunction

  task automatic send_random(input int n);
    int      goal;
    string   s;
    goal = beats_sent + n;
    while (beats_sent < goal) begin
      s = random_text();
      // A zero byte cannot live in a string; send it as a beat of its own.
      if ($urandom_range(0, 15) == 0) send_beat(8'h00, 1'b0);
      send_text(s);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    send_text("<P>Hi  there</p>\n\n x&amp;y<h2 class=a>T&#x1F600;</H2>z");
    send_text("a&#10;<br>&nbsp;&#32;b&bad;&#0;&lt&> c<blockquoteX>d<blockquotes12>e");
    send_text("&#65;&#xff;&mdash;</div>f  \n");
    send_beat(8'hFF, 1'b0);
    send_text("<<//h1 >&#xZZ41;&amp");
  endtask

  task automatic test_markers();
    write_marker(8'h00);
    send_text("<h1>a</h1><h6>b");
    write_marker(8'hFF);
    send_text("x<h3>y");
    write_marker(CH_SP);
    send_text("<h4> q<h5>");
    write_marker(CH_NL);
    send_text("z<h1><p>w");
  endtask

  task automatic test_random_phases();
    send_idle_pct = 0;   recv_stall_pct = 0;  send_random(65);
    write_marker(8'($urandom_range(0, 255)));
    send_idle_pct = 86;  recv_stall_pct = 0;  send_random(60);
    // Pause the sender until the cleaner has delivered everything.
    drain();
    send_idle_pct = 0;   recv_stall_pct = 86; send_random(60);
    write_marker(8'($urandom_range(0, 255)));
    send_idle_pct = 32;  recv_stall_pct = 32; send_random(65);
  endtask

  initial begin
    clear_stream();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_markers();
    test_random_phases();
    drain();
    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
hw/rtl/mtc_pkg.sv
hw/rtl/mtc_ctrl.sv
hw/rtl/mtc_dp.sv
hw/rtl/markup_text_cleaner.sv
test/tb_top.sv
